// ----- rtl/sm83alu_pkg.sv -----
// ----------------------------------------------------------------------------
// sm83alu_pkg
// Operation codes and stage records shared by the SM83 ALU pipeline.
// ----------------------------------------------------------------------------
package sm83alu_pkg;

    localparam int ModeW = 5;

    localparam logic [ModeW-1:0] M_ADD    = 5'd0;
    localparam logic [ModeW-1:0] M_ADC    = 5'd1;
    localparam logic [ModeW-1:0] M_SUB    = 5'd2;
    localparam logic [ModeW-1:0] M_SBC    = 5'd3;
    localparam logic [ModeW-1:0] M_AND    = 5'd4;
    localparam logic [ModeW-1:0] M_XOR    = 5'd5;
    localparam logic [ModeW-1:0] M_OR     = 5'd6;
    localparam logic [ModeW-1:0] M_CP     = 5'd7;
    localparam logic [ModeW-1:0] M_INC    = 5'd8;
    localparam logic [ModeW-1:0] M_DEC    = 5'd9;
    localparam logic [ModeW-1:0] M_DAA    = 5'd10;
    localparam logic [ModeW-1:0] M_CPL    = 5'd11;
    localparam logic [ModeW-1:0] M_SCF    = 5'd12;
    localparam logic [ModeW-1:0] M_CCF    = 5'd13;
    localparam logic [ModeW-1:0] M_RLC    = 5'd14;
    localparam logic [ModeW-1:0] M_RRC    = 5'd15;
    localparam logic [ModeW-1:0] M_RL     = 5'd16;
    localparam logic [ModeW-1:0] M_RR     = 5'd17;
    localparam logic [ModeW-1:0] M_SLA    = 5'd18;
    localparam logic [ModeW-1:0] M_SRA    = 5'd19;
    localparam logic [ModeW-1:0] M_SWAP   = 5'd20;
    localparam logic [ModeW-1:0] M_SRL    = 5'd21;
    localparam logic [ModeW-1:0] M_BIT    = 5'd22;
    localparam logic [ModeW-1:0] M_RES    = 5'd23;
    localparam logic [ModeW-1:0] M_SET    = 5'd24;
    localparam logic [ModeW-1:0] M_RLCA   = 5'd25;
    localparam logic [ModeW-1:0] M_RRCA   = 5'd26;
    localparam logic [ModeW-1:0] M_RLA    = 5'd27;
    localparam logic [ModeW-1:0] M_RRA    = 5'd28;
    localparam logic [ModeW-1:0] M_ADD16  = 5'd29;
    localparam logic [ModeW-1:0] M_ADDSP  = 5'd30;

    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_LIM = 8'h99;
    localparam logic [3:0] DAA_LO_LIM = 4'h9;

    // operands plus nibble-level carries worked out on entry
    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [7:0]       a;
        logic [7:0]       b;
        logic [15:0]      wa;
        logic [15:0]      wb;
        logic [2:0]       bi;
        logic             z;
        logic             n;
        logic             h;
        logic             c;
        logic             cin;
        logic             half_add;
        logic             half_sub;
        logic             half_16;
        logic             half_sp;
    } t_s1;

    // result with flags; zero flag still pending a test of zbyte
    typedef struct packed {
        logic [7:0]  res;
        logic [15:0] word;
        logic        wr;
        logic [7:0]  zbyte;
        logic        ztest;
        logic        zval;
        logic        n;
        logic        h;
        logic        c;
    } t_s2;

endpackage

// ----- rtl/sm83alu_exec.sv -----
// ----------------------------------------------------------------------------
// sm83alu_exec
// Middle stage logic: byte and word results and the N/H/C flags per mode.
// ----------------------------------------------------------------------------
module sm83alu_exec
    import sm83alu_pkg::*;
(
    input  t_s1 i_s1,
    output t_s2 o_s2
);

    logic [8:0]  sum9;
    logic [8:0]  diff9;
    logic [16:0] sum17;
    logic [15:0] sp_word;
    logic [8:0]  sp_lo;
    logic [7:0]  bit_mask;
    logic        daa_hi;
    logic        daa_lo;
    logic [7:0]  daa_add;
    logic [7:0]  daa_sub;

    assign sum9    = {1'b0, i_s1.a} + {1'b0, i_s1.b} + {8'b0, i_s1.cin};
    assign diff9   = {1'b0, i_s1.a} - {1'b0, i_s1.b} - {8'b0, i_s1.cin};
    assign sum17   = {1'b0, i_s1.wa} + {1'b0, i_s1.wb};
    assign sp_word = i_s1.wa + {{8{i_s1.b[7]}}, i_s1.b};
    assign sp_lo   = {1'b0, i_s1.wa[7:0]} + {1'b0, i_s1.b};
    assign bit_mask = 8'b1 << i_s1.bi;

    // decimal adjust; after an add the low-nibble test sees a[3:0] since +0x60
    // leaves the low nibble alone
    assign daa_hi  = i_s1.c || (i_s1.a > DAA_HI_LIM);
    assign daa_lo  = i_s1.h || (i_s1.a[3:0] > DAA_LO_LIM);
    assign daa_add = i_s1.a + (daa_hi ? DAA_HI_ADJ : 8'h00) + (daa_lo ? DAA_LO_ADJ : 8'h00);
    assign daa_sub = i_s1.a - (i_s1.c ? DAA_HI_ADJ : 8'h00) - (i_s1.h ? DAA_LO_ADJ : 8'h00);

    always_comb begin
        o_s2.res   = i_s1.a;
        o_s2.word  = 16'h0000;
        o_s2.wr    = 1'b1;
        o_s2.ztest = 1'b1;
        o_s2.zval  = i_s1.z;
        o_s2.n     = i_s1.n;
        o_s2.h     = i_s1.h;
        o_s2.c     = i_s1.c;
        unique case (i_s1.mode) inside
            M_ADD, M_ADC: begin
                o_s2.res = sum9[7:0];
                o_s2.c   = sum9[8];
                o_s2.h   = i_s1.half_add;
                o_s2.n   = 1'b0;
            end
            M_SUB, M_SBC: begin
                o_s2.res = diff9[7:0];
                o_s2.c   = diff9[8];
                o_s2.h   = i_s1.half_sub;
                o_s2.n   = 1'b1;
            end
            M_CP: begin
                o_s2.c  = diff9[8];
                o_s2.h  = i_s1.half_sub;
                o_s2.n  = 1'b1;
                o_s2.wr = 1'b0;
            end
            M_AND: begin
                o_s2.res = i_s1.a & i_s1.b;
                o_s2.n = 1'b0; o_s2.h = 1'b1; o_s2.c = 1'b0;
            end
            M_XOR: begin
                o_s2.res = i_s1.a ^ i_s1.b;
                o_s2.n = 1'b0; o_s2.h = 1'b0; o_s2.c = 1'b0;
            end
            M_OR: begin
                o_s2.res = i_s1.a | i_s1.b;
                o_s2.n = 1'b0; o_s2.h = 1'b0; o_s2.c = 1'b0;
            end
            M_INC: begin
                o_s2.res = i_s1.a + 8'd1;
                o_s2.h   = (i_s1.a[3:0] == 4'hf);
                o_s2.n   = 1'b0;
            end
            M_DEC: begin
                o_s2.res = i_s1.a - 8'd1;
                o_s2.h   = (i_s1.a[3:0] == 4'h0);
                o_s2.n   = 1'b1;
            end
            M_DAA: begin
                if (!i_s1.n) begin
                    o_s2.res = daa_add;
                    o_s2.c   = daa_hi;
                end else begin
                    o_s2.res = daa_sub;
                end
                o_s2.h = 1'b0;
            end
            M_CPL: begin
                o_s2.res   = ~i_s1.a;
                o_s2.n     = 1'b1;
                o_s2.h     = 1'b1;
                o_s2.ztest = 1'b0;
            end
            M_SCF, M_CCF: begin
                o_s2.c     = (i_s1.mode == M_SCF) ? 1'b1 : ~i_s1.c;
                o_s2.n     = 1'b0;
                o_s2.h     = 1'b0;
                o_s2.wr    = 1'b0;
                o_s2.ztest = 1'b0;
            end
            M_RLC, M_RLCA: begin
                o_s2.res = {i_s1.a[6:0], i_s1.a[7]};
                o_s2.c = i_s1.a[7]; o_s2.n = 1'b0; o_s2.h = 1'b0;
            end
            M_RRC, M_RRCA: begin
                o_s2.res = {i_s1.a[0], i_s1.a[7:1]};
                o_s2.c = i_s1.a[0]; o_s2.n = 1'b0; o_s2.h = 1'b0;
            end
            M_RL, M_RLA: begin
                o_s2.res = {i_s1.a[6:0], i_s1.c};
                o_s2.c = i_s1.a[7]; o_s2.n = 1'b0; o_s2.h = 1'b0;
            end
            M_RR, M_RRA: begin
                o_s2.res = {i_s1.c, i_s1.a[7:1]};
                o_s2.c = i_s1.a[0]; o_s2.n = 1'b0; o_s2.h = 1'b0;
            end
            M_SLA: begin
                o_s2.res = {i_s1.a[6:0], 1'b0};
                o_s2.c = i_s1.a[7]; o_s2.n = 1'b0; o_s2.h = 1'b0;
            end
            M_SRA: begin
                o_s2.res = {i_s1.a[7], i_s1.a[7:1]};
                o_s2.c = i_s1.a[0]; o_s2.n = 1'b0; o_s2.h = 1'b0;
            end
            M_SWAP: begin
                o_s2.res = {i_s1.a[3:0], i_s1.a[7:4]};
                o_s2.c = 1'b0; o_s2.n = 1'b0; o_s2.h = 1'b0;
            end
            M_SRL: begin
                o_s2.res = {1'b0, i_s1.a[7:1]};
                o_s2.c = i_s1.a[0]; o_s2.n = 1'b0; o_s2.h = 1'b0;
            end
            M_BIT: begin
                o_s2.zval  = ~|(i_s1.a & bit_mask);
                o_s2.ztest = 1'b0;
                o_s2.n     = 1'b0;
                o_s2.h     = 1'b1;
                o_s2.wr    = 1'b0;
            end
            M_RES: begin
                o_s2.res   = i_s1.a & ~bit_mask;
                o_s2.ztest = 1'b0;
            end
            M_SET: begin
                o_s2.res   = i_s1.a | bit_mask;
                o_s2.ztest = 1'b0;
            end
            M_ADD16: begin
                o_s2.res   = 8'h00;
                o_s2.word  = sum17[15:0];
                o_s2.c     = sum17[16];
                o_s2.h     = i_s1.half_16;
                o_s2.n     = 1'b0;
                o_s2.ztest = 1'b0;
            end
            M_ADDSP: begin
                o_s2.res   = 8'h00;
                o_s2.word  = sp_word;
                o_s2.c     = sp_lo[8];
                o_s2.h     = i_s1.half_sp;
                o_s2.n     = 1'b0;
                o_s2.zval  = 1'b0;
                o_s2.ztest = 1'b0;
            end
            default: begin
                o_s2.wr    = 1'b0;
                o_s2.ztest = 1'b0;
            end
        endcase
        // accumulator rotates never set Z
        if (i_s1.mode == M_RLCA || i_s1.mode == M_RRCA ||
            i_s1.mode == M_RLA || i_s1.mode == M_RRA) begin
            o_s2.ztest = 1'b0;
            o_s2.zval  = 1'b0;
        end
        // cp tests the difference but returns operand a
        o_s2.zbyte = (i_s1.mode == M_CP) ? diff9[7:0] : o_s2.res;
    end

endmodule

// ----- rtl/sm83_alu_with_flags.sv -----
// ----------------------------------------------------------------------------
// sm83_alu_with_flags
// Three-stage pipelined SM83 ALU: byte/word result and Z/N/H/C flags.
// ----------------------------------------------------------------------------
//  channel | valid   | ready   | payload
//  --------+---------+---------+------------------------------------------------
//  input   | i_valid | o_ready | i_mode, i_operand_a/b, i_word_a/b, i_bit_index,
//          |         |         | i_zero_in, i_negative_in, i_half_in, i_carry_in
//  output  | o_valid | i_ready | o_byte_result, o_word_result, o_writes_back,
//          |         |         | o_zero_out, o_negative_out, o_half_out, o_carry_out
//
//  One beat per cycle in and out while i_ready is high; the stages are entry, execute, zero test.
//  The stage-2 adders and the decimal adjust set the longest path.
//  Stalls on the output back up stage by stage; bubbles are filled, so
//  o_ready drops only when all three stages hold a beat and i_ready is low.
//  Reset (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
module sm83_alu_with_flags
    import sm83alu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ModeW-1:0]  i_mode,
    input  logic [7:0]        i_operand_a,
    input  logic [7:0]        i_operand_b,
    input  logic [15:0]       i_word_a,
    input  logic [15:0]       i_word_b,
    input  logic [2:0]        i_bit_index,
    input  logic              i_zero_in,
    input  logic              i_negative_in,
    input  logic              i_half_in,
    input  logic              i_carry_in,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte_result,
    output logic [15:0]       o_word_result,
    output logic              o_writes_back,
    output logic              o_zero_out,
    output logic              o_negative_out,
    output logic              o_half_out,
    output logic              o_carry_out
);

    logic r_v1, r_v2, r_v3;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    logic [7:0]  r_byte;
    logic [15:0] r_word;
    logic        r_wr, r_z, r_n, r_h, r_c;
    logic        en1, en2, en3;
    logic        cin_in;
    logic [4:0]  lo_add;
    logic [4:0]  lo_sub;
    logic [12:0] lo_16;
    logic [4:0]  lo_sp;

    assign en3 = !r_v3 || i_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;

    // carry into the byte adders only for adc and sbc
    assign cin_in = i_carry_in && (i_mode == M_ADC || i_mode == M_SBC);

    // entry stage: nibble carries
    always_comb begin
        n_s1.mode = i_mode;
        n_s1.a    = i_operand_a;
        n_s1.b    = i_operand_b;
        n_s1.wa   = i_word_a;
        n_s1.wb   = i_word_b;
        n_s1.bi   = i_bit_index;
        n_s1.z    = i_zero_in;
        n_s1.n    = i_negative_in;
        n_s1.h    = i_half_in;
        n_s1.c    = i_carry_in;
        n_s1.cin  = cin_in;
        n_s1.half_add = lo_add[4];
        n_s1.half_sub = lo_sub[4];
        n_s1.half_16  = lo_16[12];
        n_s1.half_sp  = lo_sp[4];
    end

    assign lo_add = {1'b0, i_operand_a[3:0]} + {1'b0, i_operand_b[3:0]} + {4'b0, cin_in};
    assign lo_sub = {1'b0, i_operand_a[3:0]} - {1'b0, i_operand_b[3:0]} - {4'b0, cin_in};
    assign lo_16  = {1'b0, i_word_a[11:0]} + {1'b0, i_word_b[11:0]};
    assign lo_sp  = {1'b0, i_word_a[3:0]} + {1'b0, i_operand_b[3:0]};

    sm83alu_exec u_exec (
        .i_s1 (r_s1),
        .o_s2 (n_s2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= n_s1;
        end
        if (en2) begin
            r_s2 <= n_s2;
        end
        if (en3) begin
            r_byte <= r_s2.res;
            r_word <= r_s2.word;
            r_wr   <= r_s2.wr;
            r_z    <= r_s2.ztest ? (r_s2.zbyte == 8'h00) : r_s2.zval;
            r_n    <= r_s2.n;
            r_h    <= r_s2.h;
            r_c    <= r_s2.c;
        end
    end

    assign o_valid        = r_v3;
    assign o_byte_result  = r_byte;
    assign o_word_result  = r_word;
    assign o_writes_back  = r_wr;
    assign o_zero_out     = r_z;
    assign o_negative_out = r_n;
    assign o_half_out     = r_h;
    assign o_carry_out    = r_c;

    // an accepted beat with the sink ready passes the entry, execute and zero-test registers to the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("beat did not reach output after three free cycles");

    // input is refused only when the output holds a beat the sink has not taken
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled with room in the pipeline");

    // word and byte results never both carry data
    a_result_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word_result != 16'h0000) |-> (o_byte_result == 8'h00))
        else $error("word result alongside nonzero byte result");

endmodule
